@@ rtl/core/raycs_pkg.sv @@
// Shared types and constants for the raycaster column setup block.
`timescale 1ns / 1ps
package raycs_pkg;

	// Fixed-point format of distances, directions and texture coordinates
	localparam int FRAC_BITS = 16;

	// Configuration register widths
	localparam int SH_W  = 12;
	localparam int TEX_W = 11;
	localparam int CFG_W = 12;

	// Result widths and saturation limits
	localparam int H_W      = 16;
	localparam int STEP_W   = 26;
	localparam int TXC_W    = 10;
	localparam logic [H_W-1:0]    MAX_SLICE = '1;
	localparam logic [STEP_W-1:0] MAX_TEX   = '1;

	// Pipelined divider: radix 16, one quotient digit per stage
	localparam int DIV_W      = 28;
	localparam int DEN_W      = 24;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = DIV_W / DIV_BITS;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SCREEN_HEIGHT = 2'd0,
		REG_TEX_WIDTH     = 2'd1,
		REG_TEX_HEIGHT    = 2'd2
	} cfg_reg_t;

	// Texture-side results that travel with the height computation
	typedef struct packed {
		logic [TXC_W-1:0] tx;
		logic [1:0]       face;
	} tex_info_t;

	// Row results that travel through the step division
	typedef struct packed {
		logic [H_W-1:0]  h;
		logic [SH_W-1:0] row_start;
		logic [SH_W-1:0] row_end;
		logic [H_W-2:0]  k;
		tex_info_t       tex;
	} col_info_t;

endpackage

@@ rtl/core/raycs_if.sv @@
// Handshake interfaces for hit items in and column items out.
`timescale 1ns / 1ps
interface raycs_hit_if;
	logic        valid;
	logic        ready;
	logic        hit_side;
	logic [23:0] perp_dist;
	logic [23:0] origin_x;
	logic [23:0] origin_y;
	logic signed [17:0] dir_x;
	logic signed [17:0] dir_y;
	logic        step_x_neg;
	logic        step_y_neg;

	modport source (output valid, hit_side, perp_dist, origin_x, origin_y, dir_x, dir_y,
		step_x_neg, step_y_neg, input ready);
	modport sink (input valid, hit_side, perp_dist, origin_x, origin_y, dir_x, dir_y,
		step_x_neg, step_y_neg, output ready);
endinterface

interface raycs_col_if;
	logic        valid;
	logic        ready;
	logic [15:0] slice_height;
	logic [11:0] row_start;
	logic [11:0] row_end;
	logic [9:0]  tex_column;
	logic [1:0]  face_index;
	logic [25:0] tex_step;
	logic [25:0] tex_start;

	modport source (output valid, slice_height, row_start, row_end, tex_column, face_index,
		tex_step, tex_start, input ready);
	modport sink (input valid, slice_height, row_start, row_end, tex_column, face_index,
		tex_step, tex_start, output ready);
endinterface

@@ rtl/core/raycs_div.sv @@
// Pipelined unsigned radix-16 restoring divider, one quotient digit per stage.
`timescale 1ns / 1ps
module raycs_div import raycs_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient
);

	// Four compare-subtract steps on the partial remainder
	function automatic logic [DEN_W+DIV_BITS-1:0] div_digit(
		input logic [DEN_W-1:0]    rem,
		input logic [DIV_BITS-1:0] top,
		input logic [DEN_W-1:0]    den
	);
		logic [DEN_W-1:0]    r;
		logic [DEN_W:0]      t;
		logic [DIV_BITS-1:0] q;
		r = rem;
		q = '0;
		for (int j = DIV_BITS - 1; j >= 0; j--) begin
			t = {r, top[j]};
			if (t >= {1'b0, den}) begin
				t = t - {1'b0, den};
				q[j] = 1'b1;
			end
			r = t[DEN_W-1:0];
		end
		return {r, q};
	endfunction

	logic [DEN_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_W-1:0] num_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];
	logic [DIV_W-1:0] quo_s [DIV_STAGES];

	logic [DEN_W-1:0] rem_in [DIV_STAGES];
	logic [DIV_W-1:0] num_in [DIV_STAGES];
	logic [DEN_W-1:0] den_in [DIV_STAGES];
	logic [DIV_W-1:0] quo_in [DIV_STAGES];

	// Stage inputs: the ports feed the first digit, each stage feeds the next
	always_comb begin
		for (int i = 0; i < DIV_STAGES; i++) begin
			if (i == 0) begin
				rem_in[i] = '0;
				num_in[i] = dividend;
				den_in[i] = divisor;
				quo_in[i] = '0;
			end else begin
				rem_in[i] = rem_s[i-1];
				num_in[i] = num_s[i-1];
				den_in[i] = den_s[i-1];
				quo_in[i] = quo_s[i-1];
			end
		end
	end

	// One digit per stage, remaining dividend bits shift up
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				logic [DEN_W+DIV_BITS-1:0] d;
				d = div_digit(rem_in[i], num_in[i][DIV_W-1 -: DIV_BITS], den_in[i]);
				rem_s[i] <= d[DEN_W+DIV_BITS-1:DIV_BITS];
				quo_s[i] <= {quo_in[i][DIV_W-DIV_BITS-1:0], d[DIV_BITS-1:0]};
				num_s[i] <= {num_in[i][DIV_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
				den_s[i] <= den_in[i];
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES-1];

endmodule

@@ rtl/core/raycast_column_setup.sv @@
// Top level of the raycaster wall column setup pipeline.
`timescale 1ns / 1ps
// Takes one column hit item per cycle while the output is not stalled and returns
// one column item per hit item, in order. A column item passes through 18 register
// stages before it is presented. Its path runs through two 7-stage radix-16
// dividers in series (wall height from the distance, then texture step from the
// height). A stall on the output holds the whole pipeline; an item is accepted in
// any cycle in which the output register is empty or being taken. Configuration
// writes are meant for idle periods only.
module raycast_column_setup import raycs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	raycs_hit_if.sink        hit,
	raycs_col_if.source      col
);

	localparam int PIPE_DEPTH = 2 * DIV_STAGES + 4;
	localparam int TEX_DLY    = DIV_STAGES - 4;

	logic [SH_W-1:0]  screen_height_q;
	logic [TEX_W-1:0] tex_width_q;
	logic [TEX_W-1:0] tex_height_q;
	logic [PIPE_DEPTH-1:0] valid_q;
	logic adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= SH_W'(480);
			tex_width_q     <= TEX_W'(64);
			tex_height_q    <= TEX_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				REG_TEX_WIDTH:     tex_width_q     <= cfg_data[TEX_W-1:0];
				REG_TEX_HEIGHT:    tex_height_q    <= cfg_data[TEX_W-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: the pipe moves unless a finished item waits
	assign adv       = !valid_q[PIPE_DEPTH-1] || col.ready;
	assign hit.ready = adv;
	assign col.valid = valid_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[PIPE_DEPTH-2:0], hit.valid};
		end
	end

	// Height division: (screen_height << FRAC_BITS) / perp_dist
	logic [DIV_W-1:0] quo_h;
	raycs_div u_div_h (
		.clk      (clk),
		.en       (adv),
		.dividend (DIV_W'({screen_height_q, {FRAC_BITS{1'b0}}})),
		.divisor  (hit.perp_dist),
		.quotient (quo_h)
	);

	// Stage 1: pick the wall axis and form the hit offset product
	logic signed [17:0] dir_sel;
	logic [23:0]        org_sel;
	logic signed [42:0] prod_hit;
	logic [15:0] pfrac_s1, org_s1;
	logic        mirror_s1, dz_s1;
	logic [1:0]  face_s1;

	always_comb begin
		dir_sel  = hit.hit_side ? hit.dir_x : hit.dir_y;
		org_sel  = hit.hit_side ? hit.origin_x : hit.origin_y;
		prod_hit = $signed({1'b0, hit.perp_dist}) * dir_sel;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pfrac_s1  <= prod_hit[FRAC_BITS+15:FRAC_BITS];
			org_s1    <= org_sel[15:0];
			mirror_s1 <= hit.hit_side ? hit.dir_y[17] : (!hit.dir_x[17] && hit.dir_x != '0);
			face_s1   <= hit.hit_side ? (hit.step_y_neg ? 2'd2 : 2'd3)
				: (hit.step_x_neg ? 2'd0 : 2'd1);
			dz_s1     <= (hit.perp_dist == '0);
		end
	end

	// Stages 2-4: fraction of the hit, scale by texture width, mirror
	logic [15:0] frac_s2;
	logic        mirror_s2, mirror_s3;
	logic [1:0]  face_s2, face_s3;
	logic [26:0] txp_s3;
	logic [TEX_W-1:0] tx_raw;
	logic [TEX_W-1:0] tx_mir;
	tex_info_t tex_s4;
	tex_info_t tex_dly [TEX_DLY];
	logic dz_s2, dz_s3, dz_s4;
	logic dz_dly [TEX_DLY];

	always_comb begin
		tx_raw = txp_s3[26:FRAC_BITS];
		tx_mir = (tex_width_q == '0) ? '0 : tex_width_q - tx_raw - TEX_W'(1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frac_s2   <= org_s1 + pfrac_s1;
			mirror_s2 <= mirror_s1;
			face_s2   <= face_s1;
			dz_s2     <= dz_s1;
			txp_s3    <= 27'(frac_s2) * 27'(tex_width_q);
			mirror_s3 <= mirror_s2;
			face_s3   <= face_s2;
			dz_s3     <= dz_s2;
			tex_s4.tx   <= mirror_s3 ? tx_mir[TXC_W-1:0] : tx_raw[TXC_W-1:0];
			tex_s4.face <= face_s3;
			dz_s4       <= dz_s3;
			for (int i = 0; i < TEX_DLY; i++) begin
				tex_dly[i] <= (i == 0) ? tex_s4 : tex_dly[i-1];
				dz_dly[i]  <= (i == 0) ? dz_s4 : dz_dly[i-1];
			end
		end
	end

	// Stage 8: saturate the height and place the slice on screen
	logic [H_W-1:0]  h_c;
	logic [H_W-2:0]  h2_c;
	logic [SH_W-2:0] half_c;
	logic [H_W-1:0]  end_c;
	col_info_t col_s8;

	always_comb begin
		if (dz_dly[TEX_DLY-1] || quo_h > DIV_W'(MAX_SLICE)) begin
			h_c = MAX_SLICE;
		end else begin
			h_c = quo_h[H_W-1:0];
		end
		h2_c   = h_c[H_W-1:1];
		half_c = screen_height_q[SH_W-1:1];
		end_c  = H_W'(half_c) + H_W'(h2_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s8.h   <= h_c;
			col_s8.tex <= tex_dly[TEX_DLY-1];
			if (h2_c >= (H_W-1)'(half_c)) begin
				col_s8.row_start <= '0;
				col_s8.k         <= h2_c - (H_W-1)'(half_c);
			end else begin
				col_s8.row_start <= SH_W'(half_c) - h2_c[SH_W-1:0];
				col_s8.k         <= '0;
			end
			if (end_c >= H_W'(screen_height_q)) begin
				col_s8.row_end <= (screen_height_q == '0) ? '0 : screen_height_q - SH_W'(1);
			end else begin
				col_s8.row_end <= end_c[SH_W-1:0];
			end
		end
	end

	// Step division: (tex_height << FRAC_BITS) / height
	logic [DIV_W-1:0] quo_s;
	raycs_div u_div_s (
		.clk      (clk),
		.en       (adv),
		.dividend (DIV_W'({tex_height_q, {FRAC_BITS{1'b0}}})),
		.divisor  (DEN_W'(col_s8.h)),
		.quotient (quo_s)
	);

	col_info_t col_dly [DIV_STAGES];
	col_info_t col_s16, col_s17;
	logic [STEP_W-1:0] step_s16, step_s17;
	logic [STEP_W+H_W-2:0] prod_s17;

	// Stages 9-18: carry rows, saturate step, scale start, saturate start
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				col_dly[i] <= (i == 0) ? col_s8 : col_dly[i-1];
			end
			col_s16 <= col_dly[DIV_STAGES-1];
			if (col_dly[DIV_STAGES-1].h == '0 || quo_s > DIV_W'(MAX_TEX)) begin
				step_s16 <= MAX_TEX;
			end else begin
				step_s16 <= quo_s[STEP_W-1:0];
			end
			col_s17  <= col_s16;
			step_s17 <= step_s16;
			prod_s17 <= (STEP_W+H_W-1)'(col_s16.k) * (STEP_W+H_W-1)'(step_s16);
			col.slice_height <= col_s17.h;
			col.row_start    <= col_s17.row_start;
			col.row_end      <= col_s17.row_end;
			col.tex_column   <= col_s17.tex.tx;
			col.face_index   <= col_s17.tex.face;
			col.tex_step     <= step_s17;
			col.tex_start    <= (prod_s17 > (STEP_W+H_W-1)'(MAX_TEX))
				? MAX_TEX : prod_s17[STEP_W-1:0];
		end
	end

endmodule
